// File: src/tsk_pkg.sv
`timescale 1ns / 1ps
// Shared widths, defaults and the control bundle of the in-degree counter bank.
package tsk_pkg;

	// Width of one adjacency row and of the vertex field.
	localparam int ROW_W = 16;
	localparam int VIDX_W = 4;

	// Vertex count register.
	localparam int VC_W = 5;
	localparam logic [VC_W-1:0] VC_RESET = 5'd16;

	// In-degree counters hold up to one edge per row.
	localparam int DEG_W = 5;

	// Default vertex capacity.
	localparam int MAX_VERTICES_DEF = 16;

	// Operation requested from the counter bank in one cycle.
	typedef struct packed {
		logic inc;
		logic dec;
		logic clr;
	} deg_op_t;

endpackage

// File: src/tsk_degree_bank.sv
`timescale 1ns / 1ps
// One in-degree counter per vertex, all updated in parallel.
module tsk_degree_bank #(
	parameter int LANES = tsk_pkg::MAX_VERTICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsk_pkg::deg_op_t     op,
	input  logic [LANES-1:0]     sel,
	output logic [LANES-1:0]     zero,
	output logic [LANES-1:0]     one
);

	logic [tsk_pkg::DEG_W-1:0] cnt_q [LANES];

	// Count up on loaded edges, count down on visited edges, saturating at zero; clr clears all.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) cnt_q[i] <= '0;
		end else if (op.clr) begin
			for (int i = 0; i < LANES; i++) cnt_q[i] <= '0;
		end else begin
			for (int i = 0; i < LANES; i++) begin
				if (op.inc && sel[i]) begin
					cnt_q[i] <= cnt_q[i] + tsk_pkg::DEG_W'(1);
				end else if (op.dec && sel[i] && (cnt_q[i] != '0)) begin
					cnt_q[i] <= cnt_q[i] - tsk_pkg::DEG_W'(1);
				end
			end
		end
	end

	// Status flags per counter.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			zero[i] = (cnt_q[i] == '0);
			one[i]  = (cnt_q[i] == tsk_pkg::DEG_W'(1));
		end
	end

endmodule

// File: src/topological_sort_kahn_unit.sv
`timescale 1ns / 1ps
// Kahn topological sort over an adjacency matrix loaded one row per transfer.
// Input: a row transfer is taken when start is high and busy is low. It carries
// row_index, row_bits (bit j = edge to vertex j) and final_row. Each row is a
// read of the stored row from the adjacency memory, then the merged write and
// the in-degree increments.
// Configuration: cfg_wr_en writes cfg_wr_data into the vertex count; the user must
// do so only while idle, as the block itself does not enforce it.
// Output: every result is shown for one cycle with result_valid; the receiver
// cannot stall, so nothing is held back. After the final row, the sort seeds
// the queue, then per dequeued vertex does a queue memory read, an adjacency
// memory read and a parallel decrement, and enqueues each vertex that becomes
// ready. The status result closes the run with end_of_run set. Both memories
// have one registered read port, so each step waits for its read data. As the
// status result appears, the rows and counters are cleared at once, the rows
// through per-row valid bits, and busy drops.
// Reset: vertex count 16, empty graph, idle.
module topological_sort_kahn_unit #(
	parameter int MAX_VERTICES = tsk_pkg::MAX_VERTICES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [tsk_pkg::VIDX_W-1:0] row_index,
	input  logic [tsk_pkg::ROW_W-1:0]  row_bits,
	input  logic                      final_row,
	input  logic                      cfg_wr_en,
	input  logic [tsk_pkg::VC_W-1:0]   cfg_wr_data,
	output logic                      result_valid,
	output logic [tsk_pkg::VIDX_W-1:0] vertex,
	output logic                      is_status,
	output logic                      has_cycle,
	output logic                      end_of_run
);

	localparam int LANES = (MAX_VERTICES < tsk_pkg::ROW_W) ? MAX_VERTICES : tsk_pkg::ROW_W;
	localparam int LIDX = $clog2(LANES);
	localparam int CW = $clog2(LANES + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_SEED = 3'd2;
	localparam logic [2:0] ST_ENQ  = 3'd3;
	localparam logic [2:0] ST_QRD  = 3'd4;
	localparam logic [2:0] ST_ARD  = 3'd5;
	localparam logic [2:0] ST_STAT = 3'd6;

	logic [2:0]               state_q;
	logic [tsk_pkg::VC_W-1:0] vertex_count_q;
	logic [CW-1:0]            n_w;
	logic [LANES-1:0]         act_mask;
	logic                     accept;

	logic [LANES-1:0]         adj_mem [LANES];
	logic [LANES-1:0]         adj_rdata_q;
	logic                     adj_rvalid_q;
	logic [LIDX-1:0]          adj_raddr;
	logic [LANES-1:0]         adj_old;
	logic                     adj_we;
	logic [LANES-1:0]         row_valid_q;

	logic [LIDX-1:0]          queue_mem [LANES];
	logic [LIDX-1:0]          queue_rdata_q;
	logic                     q_we;
	logic [LIDX-1:0]          enc_idx;

	logic [CW-1:0]            head_q;
	logic [CW-1:0]            tail_q;
	logic [CW-1:0]            processed_q;
	logic [LANES-1:0]         pending_q;

	logic [LIDX-1:0]          row_q;
	logic                     row_ok_q;
	logic [LANES-1:0]         bits_q;
	logic                     last_q;
	logic [LIDX-1:0]          cur_q;

	tsk_pkg::deg_op_t         deg_op;
	logic [LANES-1:0]         deg_sel;
	logic [LANES-1:0]         deg_zero;
	logic [LANES-1:0]         deg_one;

	logic                     res_valid_q;
	logic [tsk_pkg::VIDX_W-1:0] res_vertex_q;
	logic                     res_status_q;
	logic                     res_cycle_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Vertex count in effect, clipped to the capacity.
	assign n_w = (vertex_count_q > tsk_pkg::VC_W'(LANES)) ? CW'(LANES) : CW'(vertex_count_q);

	always_comb begin
		for (int i = 0; i < LANES; i++) act_mask[i] = (n_w > CW'(i));
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= tsk_pkg::VC_RESET;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	// Stored row as seen through its valid bit.
	assign adj_old = adj_rvalid_q ? adj_rdata_q : '0;
	assign adj_we  = (state_q == ST_LOAD) && row_ok_q;
	assign adj_raddr = (state_q == ST_IDLE) ? row_index[LIDX-1:0] : queue_rdata_q;

	// Adjacency memory: one read port, one write port.
	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[row_q] <= adj_old | bits_q;
		adj_rdata_q  <= adj_mem[adj_raddr];
		adj_rvalid_q <= row_valid_q[adj_raddr];
	end

	// Lowest pending vertex enters the queue first.
	always_comb begin
		enc_idx = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (pending_q[i]) enc_idx = LIDX'(i);
		end
	end

	assign q_we = (state_q == ST_ENQ) && (pending_q != '0);

	// Order queue memory with one write port and one registered read port at the head.
	always_ff @(posedge clk) begin
		if (q_we) queue_mem[tail_q[LIDX-1:0]] <= enc_idx;
		queue_rdata_q <= queue_mem[head_q[LIDX-1:0]];
	end

	// Counter bank control.
	always_comb begin
		deg_op.inc = adj_we;
		deg_op.dec = (state_q == ST_ARD);
		deg_op.clr = (state_q == ST_STAT);
		deg_sel = (state_q == ST_ARD) ? (adj_old & act_mask) : (bits_q & ~adj_old);
	end

	tsk_degree_bank #(
		.LANES (LANES)
	) u_degree_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (deg_op),
		.sel    (deg_sel),
		.zero   (deg_zero),
		.one    (deg_one)
	);

	// Load item registers and the current dequeued vertex.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= row_index[LIDX-1:0];
			bits_q <= row_bits[LANES-1:0] & act_mask;
			last_q <= final_row;
		end
		if (state_q == ST_QRD) cur_q <= queue_rdata_q;
	end

	// Sequencer for load, seed, enqueue, dequeue and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_ok_q    <= 1'b0;
			row_valid_q <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			processed_q <= '0;
			pending_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_ok_q <= ({1'b0, row_index} < 5'(n_w));
						state_q  <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (row_ok_q) row_valid_q[row_q] <= 1'b1;
					state_q <= last_q ? ST_SEED : ST_IDLE;
				end
				ST_SEED: begin
					pending_q   <= deg_zero & act_mask;
					head_q      <= '0;
					tail_q      <= '0;
					processed_q <= '0;
					state_q     <= ST_ENQ;
				end
				ST_ENQ: begin
					if (pending_q != '0) begin
						tail_q    <= tail_q + CW'(1);
						pending_q <= pending_q & (pending_q - LANES'(1));
					end else if (head_q < tail_q) begin
						state_q <= ST_QRD;
					end else begin
						state_q <= ST_STAT;
					end
				end
				ST_QRD: begin
					state_q <= ST_ARD;
				end
				ST_ARD: begin
					head_q      <= head_q + CW'(1);
					processed_q <= processed_q + CW'(1);
					pending_q   <= adj_old & act_mask & deg_one;
					res_valid_q <= 1'b1;
					state_q     <= ST_ENQ;
				end
				ST_STAT: begin
					row_valid_q <= '0;
					head_q      <= '0;
					tail_q      <= '0;
					processed_q <= '0;
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_ARD) begin
			res_vertex_q <= tsk_pkg::VIDX_W'(cur_q);
			res_status_q <= 1'b0;
			res_cycle_q  <= 1'b0;
		end else if (state_q == ST_STAT) begin
			res_vertex_q <= '0;
			res_status_q <= 1'b1;
			res_cycle_q  <= (processed_q != n_w);
		end
	end

	assign result_valid = res_valid_q;
	assign vertex       = res_vertex_q;
	assign is_status    = res_status_q;
	assign has_cycle    = res_cycle_q;
	assign end_of_run   = res_status_q;

endmodule

// File: src/tsk_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the sort unit.
module tsk_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       result_valid,
	input logic [tsk_pkg::VIDX_W-1:0] vertex,
	input logic                       is_status,
	input logic                       has_cycle,
	input logic                       end_of_run
);

	// An accepted transfer always makes the unit busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("unit not busy after an accepted row");

	// The status result closes the run with vertex zero.
	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_status |-> end_of_run && (vertex == '0))
		else $error("status result without end of run");

	// Vertex results carry no status flags.
	a_vertex_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_status |-> !has_cycle && !end_of_run)
		else $error("vertex result with status flags");

	// A vertex result comes mid-run; the status result comes as the unit goes idle.
	a_vertex_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (busy == !is_status))
		else $error("busy disagrees with result kind");

endmodule

bind topological_sort_kahn_unit tsk_checker u_tsk_checker (.*);

// File: test/tb_topological_sort_kahn_unit.sv
`timescale 1ns / 1ps
module tb_topological_sort_kahn_unit;

	// One result of the sort as it appears on the result ports.
	typedef struct packed {
		logic [tsk_pkg::VIDX_W-1:0] vertex;
		logic                       is_status;
		logic                       has_cycle;
		logic                       end_of_run;
	} topo_result_t;

	// Mirrors the graph store and runs the sort for every final row transfer.
	class topo_scoreboard;
		logic [tsk_pkg::VC_W-1:0]  count_reg;
		logic [tsk_pkg::ROW_W-1:0] adj_rows[tsk_pkg::ROW_W];
		logic [tsk_pkg::DEG_W-1:0] indeg[tsk_pkg::ROW_W];
		topo_result_t              expected_q[$];
		int unsigned               failures;

		function new();
			count_reg = tsk_pkg::VC_RESET;
			failures = 0;
			clear_graph();
		endfunction

		function void clear_graph();
			foreach (adj_rows[i]) begin
				adj_rows[i] = '0;
				indeg[i] = '0;
			end
		endfunction

		function void write_count(logic [tsk_pkg::VC_W-1:0] value);
			count_reg = value;
		endfunction

		// Merge an accepted row; on the final row, predict the whole sorted order.
		function void note_row(logic [tsk_pkg::VIDX_W-1:0] row,
			logic [tsk_pkg::ROW_W-1:0] bits, logic fin);
			int unsigned  n;
			int unsigned  done;
			int unsigned  cur;
			int unsigned  ready_q[$];
			logic [tsk_pkg::ROW_W:0]   mask;
			logic [tsk_pkg::ROW_W-1:0] fresh;
			logic [tsk_pkg::ROW_W-1:0] cur_row;
			topo_result_t              res;
			n = (count_reg > tsk_pkg::ROW_W) ? tsk_pkg::ROW_W : count_reg;
			mask = (17'd1 << n) - 17'd1;
			if (row < n) begin
				fresh = bits & mask[tsk_pkg::ROW_W-1:0] & ~adj_rows[row];
				adj_rows[row] |= fresh;
				for (int i = 0; i < n; i++)
					if (fresh[i])
						indeg[i] = indeg[i] + 1'b1;
			end
			if (!fin)
				return;
			done = 0;
			for (int i = 0; i < n; i++)
				if (indeg[i] == 0)
					ready_q.push_back(i);
			while (ready_q.size() != 0) begin
				cur = ready_q.pop_front();
				cur_row = adj_rows[cur];
				done++;
				res.vertex = cur[tsk_pkg::VIDX_W-1:0];
				res.is_status = 1'b0;
				res.has_cycle = 1'b0;
				res.end_of_run = 1'b0;
				expected_q.push_back(res);
				// A counter already at zero is left alone.
				for (int i = 0; i < n; i++) begin
					if (cur_row[i] && indeg[i] != 0) begin
						indeg[i] = indeg[i] - 1'b1;
						if (indeg[i] == 0)
							ready_q.push_back(i);
					end
				end
			end
			res.vertex = '0;
			res.is_status = 1'b1;
			res.has_cycle = (done != n);
			res.end_of_run = 1'b1;
			expected_q.push_back(res);
			clear_graph();
		endfunction

		function void check_result(topo_result_t got);
			topo_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("unexpected result: vertex %0d is_status %0b", got.vertex, got.is_status);
				failures++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (got.vertex !== exp_res.vertex) begin
				$error("vertex: expected %0d, actual %0d", exp_res.vertex, got.vertex);
				failures++;
			end
			if (got.is_status !== exp_res.is_status) begin
				$error("is_status: expected %0b, actual %0b", exp_res.is_status, got.is_status);
				failures++;
			end
			if (got.has_cycle !== exp_res.has_cycle) begin
				$error("has_cycle: expected %0b, actual %0b", exp_res.has_cycle, got.has_cycle);
				failures++;
			end
			if (got.end_of_run !== exp_res.end_of_run) begin
				$error("end_of_run: expected %0b, actual %0b", exp_res.end_of_run,
					got.end_of_run);
				failures++;
			end
		endfunction
	endclass

	// Settle time after the last result before the count may change.
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ROWS = 360;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [tsk_pkg::VIDX_W-1:0]   row_index;
	logic [tsk_pkg::ROW_W-1:0]    row_bits;
	logic                         final_row;
	logic                         cfg_wr_en;
	logic [tsk_pkg::VC_W-1:0]     cfg_wr_data;
	logic                         result_valid;
	logic [tsk_pkg::VIDX_W-1:0]   vertex;
	logic                         is_status;
	logic                         has_cycle;
	logic                         end_of_run;

	topo_scoreboard sb = new();
	int unsigned sender_idle_pct;
	int unsigned rows_sent;

	topological_sort_kahn_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.row_index(row_index),
		.row_bits(row_bits),
		.final_row(final_row),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.result_valid(result_valid),
		.vertex(vertex),
		.is_status(is_status),
		.has_cycle(has_cycle),
		.end_of_run(end_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every strobed result is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result({vertex, is_status, has_cycle, end_of_run});
	end

	// Drive one row transfer, with random idle cycles ahead of it.
	// Entered and left right after a falling edge.
	task automatic send_row(logic [tsk_pkg::VIDX_W-1:0] row, logic [tsk_pkg::ROW_W-1:0] bits,
		logic fin);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			row_index <= tsk_pkg::VIDX_W'($urandom);
			row_bits <= tsk_pkg::ROW_W'($urandom);
			final_row <= 1'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		row_index <= row;
		row_bits <= bits;
		final_row <= fin;
		do
			@(posedge clk);
		while (busy);
		sb.note_row(row, bits, fin);
		rows_sent++;
		@(negedge clk);
	endtask

	// Wait until the block is idle, then write the vertex count.
	task automatic write_count(logic [tsk_pkg::VC_W-1:0] value);
		start <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		sb.write_count(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random graph: mostly acyclic under a shuffled vertex order, sometimes arbitrary.
	task automatic send_graph();
		int unsigned n;
		int unsigned num_rows;
		int unsigned tmp;
		int unsigned j;
		int unsigned pos[tsk_pkg::ROW_W];
		bit          acyclic;
		bit          leave_open;
		logic [tsk_pkg::VIDX_W-1:0] row;
		logic [tsk_pkg::ROW_W-1:0]  bits;
		n = (sb.count_reg > tsk_pkg::ROW_W) ? tsk_pkg::ROW_W : sb.count_reg;
		num_rows = $urandom_range(1, n + 2);
		acyclic = ($urandom_range(0, 9) < 7);
		leave_open = ($urandom_range(0, 99) < 8);
		foreach (pos[i])
			pos[i] = i;
		for (int i = tsk_pkg::ROW_W - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = pos[i];
			pos[i] = pos[j];
			pos[j] = tmp;
		end
		for (int k = 0; k < num_rows; k++) begin
			if (n > 0 && $urandom_range(0, 9) != 0)
				row = tsk_pkg::VIDX_W'($urandom_range(0, n - 1));
			else
				row = tsk_pkg::VIDX_W'($urandom);
			bits = tsk_pkg::ROW_W'($urandom);
			if ($urandom_range(0, 1))
				bits &= tsk_pkg::ROW_W'($urandom);
			if ($urandom_range(0, 1))
				bits &= tsk_pkg::ROW_W'($urandom);
			// Keep only edges that point later in the shuffled order.
			if (acyclic)
				for (int b = 0; b < tsk_pkg::ROW_W; b++)
					if (pos[b] <= pos[row])
						bits[b] = 1'b0;
			send_row(row, bits, (k == num_rows - 1) && !leave_open);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		row_index = '0;
		row_bits = '0;
		final_row = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		sender_idle_pct = 13;
		rows_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full graph at the reset count: repeated row, chain, self loop, cycle.
		send_row(4'd0, 16'hFFFE, 1'b0);
		send_row(4'd0, 16'h0006, 1'b0);
		send_row(4'd15, 16'h0000, 1'b1);
		send_row(4'd5, 16'h0020, 1'b1);
		send_row(4'd3, 16'hFFFF, 1'b0);
		send_row(4'd7, 16'h0008, 1'b1);
		send_row(4'd9, 16'h0000, 1'b1);
		// Empty graph.
		write_count(5'd0);
		send_row(4'd0, 16'hFFFF, 1'b1);
		send_row(4'd15, 16'h8001, 1'b1);
		// Single vertex: self loop, ignored bits, row out of range.
		write_count(5'd1);
		send_row(4'd0, 16'hFFFF, 1'b1);
		send_row(4'd0, 16'hFFFE, 1'b1);
		send_row(4'd1, 16'h0001, 1'b1);
		// Count above the row width is clipped.
		write_count(5'd31);
		send_row(4'd15, 16'h8000, 1'b1);
		// Count lowered between loading and sorting.
		write_count(5'd16);
		send_row(4'd2, 16'hC000, 1'b0);
		send_row(4'd14, 16'h0004, 1'b0);
		write_count(5'd8);
		send_row(4'd12, 16'h00FF, 1'b0);
		send_row(4'd1, 16'h0004, 1'b1);

		// Random graphs in three idle phases.
		rows_sent = 0;
		while (rows_sent < RANDOM_ROWS) begin
			if (rows_sent < RANDOM_ROWS / 3)
				sender_idle_pct = 13;
			else if (rows_sent < 2 * RANDOM_ROWS / 3)
				sender_idle_pct = 76;
			else
				sender_idle_pct = 0;
			if ($urandom_range(0, 9) < 3) begin
				case ($urandom_range(0, 9))
					0: write_count(5'd0);
					1: write_count(5'd1);
					2: write_count(5'd16);
					3: write_count(tsk_pkg::VC_W'($urandom_range(17, 31)));
					default: write_count(tsk_pkg::VC_W'($urandom_range(2, 15)));
				endcase
			end
			send_graph();
		end
		send_row(4'd0, 16'h0000, 1'b1);
		start <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("tb_topological_sort_kahn_unit OK");
		else
			$display("tb_topological_sort_kahn_unit NOT OK");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#8_000_000;
		$display("tb_topological_sort_kahn_unit NOT OK");
		$finish;
	end

endmodule
